// ----- hdl/pl0sm_pkg.sv -----
package pl0sm_pkg;

  localparam int STK_DEPTH   = 2048;
  localparam int STK_AW      = $clog2(STK_DEPTH);
  localparam int DISP_DEPTH  = 5;
  localparam int DISP_AW     = $clog2(DISP_DEPTH);
  localparam int REG_RESERVE = 20;
  localparam int STK_LIMIT   = STK_DEPTH - REG_RESERVE;
  localparam int CODE_AW     = 8;
  localparam int IN_W        = 48;
  localparam int OUT_W       = 48;

  // instruction kinds
  localparam logic [3:0] K_LIT = 4'd0;
  localparam logic [3:0] K_LOD = 4'd1;
  localparam logic [3:0] K_STO = 4'd2;
  localparam logic [3:0] K_CAL = 4'd3;
  localparam logic [3:0] K_RET = 4'd4;
  localparam logic [3:0] K_ICT = 4'd5;
  localparam logic [3:0] K_JMP = 4'd6;
  localparam logic [3:0] K_JPC = 4'd7;
  localparam logic [3:0] K_OPR = 4'd8;
  localparam logic [3:0] K_NOP = 4'd15;

  // opr operations
  localparam logic [3:0] OP_NEG = 4'd0;
  localparam logic [3:0] OP_ADD = 4'd1;
  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_MUL = 4'd3;
  localparam logic [3:0] OP_DIV = 4'd4;
  localparam logic [3:0] OP_ODD = 4'd5;
  localparam logic [3:0] OP_EQ  = 4'd6;
  localparam logic [3:0] OP_LT  = 4'd7;
  localparam logic [3:0] OP_GT  = 4'd8;
  localparam logic [3:0] OP_NE  = 4'd9;
  localparam logic [3:0] OP_LE  = 4'd10;
  localparam logic [3:0] OP_GE  = 4'd11;
  localparam logic [3:0] OP_WRT = 4'd12;
  localparam logic [3:0] OP_NL  = 4'd13;

  localparam logic [1:0] PK_NONE = 2'd0;
  localparam logic [1:0] PK_NUM  = 2'd1;
  localparam logic [1:0] PK_NL   = 2'd2;

  localparam logic [1:0] FLT_NONE = 2'd0;
  localparam logic [1:0] FLT_OVF  = 2'd1;
  localparam logic [1:0] FLT_DIV0 = 2'd2;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  op;
    logic [2:0]  lv;
    logic [31:0] opd;
  } instr_t;

  typedef struct packed {
    logic [1:0]         fault;
    logic [31:0]        pval;
    logic [1:0]         pkind;
    logic               halted;
    logic [CODE_AW-1:0] next_pc;
  } res_t;

  typedef logic [DISP_DEPTH-1:0][STK_AW-1:0] disp_t;

endpackage

// ----- hdl/pl0sm_front.sv -----
module pl0sm_front
  import pl0sm_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [IN_W-1:0] in_tdata,
  input  logic            mem_ready,
  output logic            q_valid,
  output instr_t          q_head,
  input  logic            q_pop
);

  instr_t     q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  instr_t     dec;
  logic       push;

  // classify: unknown kinds and operations become a plain pc advance
  always_comb begin
    dec.kind = in_tdata[3:0];
    dec.op   = in_tdata[7:4];
    dec.lv   = in_tdata[10:8];
    dec.opd  = in_tdata[42:11];
    if (dec.kind > K_OPR || (dec.kind == K_OPR && dec.op > OP_NL)) begin
      dec.kind = K_NOP;
    end
  end

  assign in_tready = mem_ready && (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_head    = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= dec;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ----- hdl/pl0sm_div.sv -----
module pl0sm_div
  import pl0sm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quo
);

  logic        busy_r, done_r, neg_r;
  logic [4:0]  cnt_r;
  logic [31:0] rem_r, q_r, d_r, quo_r;
  logic [32:0] sh;
  logic        ge;
  logic [31:0] rem_nxt, q_nxt;

  // restoring division on magnitudes, one quotient bit per cycle
  always_comb begin
    sh      = {rem_r, q_r[31]};
    ge      = (sh >= {1'b0, d_r});
    rem_nxt = ge ? 32'(sh - {1'b0, d_r}) : sh[31:0];
    q_nxt   = {q_r[30:0], ge};
  end

  assign done = done_r;
  assign quo  = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= num[31] ? 32'(0 - num) : num;
      d_r   <= den[31] ? 32'(0 - den) : den;
      neg_r <= num[31] ^ den[31];
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'd31) quo_r <= neg_r ? 32'(0 - q_nxt) : q_nxt;
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == 5'd31);
      if (start) busy_r <= 1'b1;
      else if (busy_r && cnt_r == 5'd31) busy_r <= 1'b0;
    end
  end

endmodule

// ----- hdl/pl0sm_exec.sv -----
module pl0sm_exec
  import pl0sm_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  output logic   mem_ready,
  input  logic   q_valid,
  input  instr_t q_head,
  output logic   q_pop,
  output logic   out_valid,
  input  logic   out_take,
  output res_t   out_res
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_A    = 3'd2;
  localparam logic [2:0] ST_B    = 3'd3;
  localparam logic [2:0] ST_C    = 3'd4;
  localparam logic [2:0] ST_D    = 3'd5;
  localparam logic [2:0] ST_MUL  = 3'd6;
  localparam logic [2:0] ST_DIV  = 3'd7;

  logic [31:0]        mem [STK_DEPTH];
  logic [31:0]        rd_q;
  logic               mem_we;
  logic [STK_AW-1:0]  mem_wa, mem_ra;
  logic [31:0]        mem_wd;

  logic [2:0]         st_r, st_nxt;
  instr_t             cur_r, cur_nxt;
  logic [STK_AW-1:0]  top_r, top_nxt, clr_r;
  logic [CODE_AW-1:0] pc_r, pc_nxt, pc_inc;
  disp_t              disp_r, disp_nxt;
  logic [31:0]        ret_r, ret_nxt, b_r, b_nxt, prod_r, prod_nxt;
  logic               out_valid_r;
  res_t               out_res_r, res;
  logic               fin;
  logic               div_start, div_done;
  logic [31:0]        div_q;
  logic [3:0]         lv_up;
  logic [STK_AW-1:0]  d_lv, d_up;
  logic signed [33:0] ict_sum;
  logic [31:0]        a, r;

  function automatic logic [STK_AW-1:0] disp_rd(input disp_t d, input logic [3:0] idx);
    return (idx < 4'(DISP_DEPTH)) ? d[idx[DISP_AW-1:0]] : '0;
  endfunction

  pl0sm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (rd_q),
    .den   (b_r),
    .done  (div_done),
    .quo   (div_q)
  );

  assign mem_ready = (st_r != ST_CLR);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign pc_inc    = pc_r + 1'b1;
  assign lv_up     = {1'b0, cur_r.lv} + 4'd1;
  assign d_lv      = disp_rd(disp_r, {1'b0, cur_r.lv});
  assign d_up      = disp_rd(disp_r, lv_up);
  assign ict_sum   = $signed({23'b0, top_r}) + $signed({{2{cur_r.opd[31]}}, cur_r.opd});
  assign a         = rd_q;

  // binary opr result, left operand from memory, right operand held
  always_comb begin
    case (cur_r.op)
      OP_ADD:  r = a + b_r;
      OP_SUB:  r = a - b_r;
      OP_EQ:   r = {31'b0, a == b_r};
      OP_LT:   r = {31'b0, $signed(a) < $signed(b_r)};
      OP_GT:   r = {31'b0, $signed(a) > $signed(b_r)};
      OP_NE:   r = {31'b0, a != b_r};
      OP_LE:   r = {31'b0, $signed(a) <= $signed(b_r)};
      OP_GE:   r = {31'b0, $signed(a) >= $signed(b_r)};
      default: r = a;
    endcase
  end

  always_comb begin
    st_nxt    = st_r;
    cur_nxt   = cur_r;
    top_nxt   = top_r;
    pc_nxt    = pc_r;
    disp_nxt  = disp_r;
    ret_nxt   = ret_r;
    b_nxt     = b_r;
    prod_nxt  = prod_r;
    mem_we    = 1'b0;
    mem_wa    = top_r;
    mem_wd    = cur_r.opd;
    mem_ra    = top_r - 1'b1;
    q_pop     = 1'b0;
    fin       = 1'b0;
    div_start = 1'b0;
    res       = '0;

    case (st_r)
      ST_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = '0;
        if (&clr_r) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid && (!out_valid_r || out_take)) begin
          q_pop   = 1'b1;
          cur_nxt = q_head;
          st_nxt  = ST_A;
        end
      end
      ST_A: begin
        pc_nxt = pc_inc;
        st_nxt = ST_B;
        case (cur_r.kind)
          K_LIT: begin
            mem_we  = 1'b1;
            top_nxt = top_r + 1'b1;
            fin     = 1'b1;
          end
          K_LOD: mem_ra = d_lv + cur_r.opd[STK_AW-1:0];
          K_STO, K_JPC: top_nxt = top_r - 1'b1;
          K_CAL: begin
            mem_we = 1'b1;
            mem_wd = {{(32-STK_AW){1'b0}}, d_up};
          end
          K_ICT: begin
            top_nxt = ict_sum[STK_AW-1:0];
            if (ict_sum < 0 || ict_sum >= 34'(STK_LIMIT)) res.fault = FLT_OVF;
            fin = 1'b1;
          end
          K_JMP: begin
            pc_nxt = cur_r.opd[CODE_AW-1:0];
            fin    = 1'b1;
          end
          K_OPR: begin
            if (cur_r.op == OP_WRT) top_nxt = top_r - 1'b1;
            if (cur_r.op == OP_NL) begin
              res.pkind = PK_NL;
              fin       = 1'b1;
            end
          end
          K_RET: ;
          default: fin = 1'b1;
        endcase
      end
      ST_B: begin
        fin = 1'b1;
        case (cur_r.kind)
          K_LOD: begin
            mem_we  = 1'b1;
            mem_wd  = rd_q;
            top_nxt = top_r + 1'b1;
          end
          K_STO: begin
            mem_we = 1'b1;
            mem_wa = d_lv + cur_r.opd[STK_AW-1:0];
            mem_wd = rd_q;
          end
          K_CAL: begin
            mem_we = 1'b1;
            mem_wa = top_r + 1'b1;
            mem_wd = {{(32-CODE_AW){1'b0}}, pc_r};
            if (lv_up < 4'(DISP_DEPTH)) disp_nxt[lv_up[DISP_AW-1:0]] = top_r;
            pc_nxt = cur_r.opd[CODE_AW-1:0];
          end
          K_RET: begin
            fin     = 1'b0;
            ret_nxt = rd_q;
            top_nxt = d_lv;
            mem_ra  = d_lv;
            st_nxt  = ST_C;
          end
          K_JPC: begin
            if (rd_q == '0) pc_nxt = cur_r.opd[CODE_AW-1:0];
          end
          default: begin
            case (cur_r.op)
              OP_NEG: begin
                mem_we = 1'b1;
                mem_wa = top_r - 1'b1;
                mem_wd = 32'(0 - rd_q);
              end
              OP_ODD: begin
                mem_we = 1'b1;
                mem_wa = top_r - 1'b1;
                mem_wd = {31'b0, rd_q[0]};
              end
              OP_WRT: begin
                res.pkind = PK_NUM;
                res.pval  = rd_q;
              end
              default: begin
                fin    = 1'b0;
                b_nxt  = rd_q;
                mem_ra = top_r - 2'd2;
                st_nxt = ST_C;
              end
            endcase
          end
        endcase
      end
      ST_C: begin
        if (cur_r.kind == K_RET) begin
          if (cur_r.lv < 3'(DISP_DEPTH)) disp_nxt[cur_r.lv[DISP_AW-1:0]] = rd_q[STK_AW-1:0];
          mem_ra = top_r + 1'b1;
          st_nxt = ST_D;
        end else if (cur_r.op == OP_MUL) begin
          prod_nxt = a * b_r;
          st_nxt   = ST_MUL;
        end else if (cur_r.op == OP_DIV) begin
          if (b_r == '0) begin
            res.fault = FLT_DIV0;
            top_nxt   = top_r - 1'b1;
            fin       = 1'b1;
          end else begin
            div_start = 1'b1;
            st_nxt    = ST_DIV;
          end
        end else begin
          mem_we  = 1'b1;
          mem_wa  = top_r - 2'd2;
          mem_wd  = r;
          top_nxt = top_r - 1'b1;
          fin     = 1'b1;
        end
      end
      ST_D: begin
        pc_nxt  = rd_q[CODE_AW-1:0];
        mem_we  = 1'b1;
        mem_wa  = top_r - cur_r.opd[STK_AW-1:0];
        mem_wd  = ret_r;
        top_nxt = top_r - cur_r.opd[STK_AW-1:0] + 1'b1;
        fin     = 1'b1;
      end
      ST_MUL: begin
        mem_we  = 1'b1;
        mem_wa  = top_r - 2'd2;
        mem_wd  = prod_r;
        top_nxt = top_r - 1'b1;
        fin     = 1'b1;
      end
      ST_DIV: begin
        if (div_done) begin
          mem_we  = 1'b1;
          mem_wa  = top_r - 2'd2;
          mem_wd  = div_q;
          top_nxt = top_r - 1'b1;
          fin     = 1'b1;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase

    if (fin) st_nxt = ST_IDLE;
    res.next_pc = pc_nxt;
    res.halted  = (pc_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    ret_r  <= ret_nxt;
    b_r    <= b_nxt;
    prod_r <= prod_nxt;
    if (fin) out_res_r <= res;
    if (!rst_n) begin
      st_r        <= ST_CLR;
      clr_r       <= '0;
      top_r       <= '0;
      pc_r        <= '0;
      disp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      clr_r  <= clr_r + 1'b1;
      top_r  <= top_nxt;
      pc_r   <= pc_nxt;
      disp_r <= disp_nxt;
      if (fin) out_valid_r <= 1'b1;
      else if (out_take) out_valid_r <= 1'b0;
    end
  end

endmodule

// ----- hdl/pl0_stack_machine_step.sv -----
// channel | dir | ports                            | item
// in      | in  | in_tvalid in_tready in_tdata     | one p-code instruction
// out     | out | out_tvalid out_tready out_tdata  | next pc, halt, print, fault
//
// Each item steps through executor states in order. Lit, ict, jmp, newline
// and unknown codes finish in state A; lod, sto, cal, jpc, neg, odd and write
// in B; add/sub/compare and a division by zero in C; mul in MUL and ret in D,
// both after C; a division waits in DIV on the one-bit-per-cycle divider. The
// stack memory does one registered read and one write a cycle. After reset it
// is cleared one word a cycle, with in_tready low meanwhile. A two-entry queue
// takes items until full while the executor works or waits on out_tready.
module pl0_stack_machine_step
  import pl0sm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // [3:0] kind, [7:4] operation, [10:8] level, [42:11] operand, rest zero
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // [7:0] next_pc, [8] halted, [10:9] print_kind, [42:11] print_value,
  // [44:43] fault, rest zero
  output logic [OUT_W-1:0] out_tdata
);

  logic   mem_ready;
  logic   q_valid, q_pop;
  instr_t q_head;
  res_t   res;

  // front: accept, classify and queue instructions
  pl0sm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .mem_ready (mem_ready),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  // back: stack memory, display, pc and the result register
  pl0sm_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .mem_ready (mem_ready),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_take  (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {{(OUT_W - $bits(res_t)){1'b0}}, res};

endmodule

// ----- verif/testbench.sv -----
module testbench;
  import pl0sm_pkg::*;

  logic            clk;
  logic            rst_n;
  logic            in_tvalid;
  logic            in_tready;
  // [3:0] kind, [7:4] operation, [10:8] level, [42:11] operand, rest zero
  logic [IN_W-1:0] in_tdata;
  logic            out_tvalid;
  logic            out_tready;
  // [7:0] next_pc, [8] halted, [10:9] print_kind, [42:11] print_value,
  // [44:43] fault, rest zero
  logic [OUT_W-1:0] out_tdata;

  int n_fail = 0;
  int n_sent = 0;

  // Machine shadow: executes each accepted instruction and queues the step result.
  class pcode_scoreboard;
    logic [31:0]        stk[STK_DEPTH];
    logic [STK_AW-1:0]  disp[DISP_DEPTH];
    logic [STK_AW-1:0]  top;
    logic [CODE_AW-1:0] pc;
    res_t               pending[$];

    function new();
      foreach (stk[i]) stk[i] = '0;
      foreach (disp[i]) disp[i] = '0;
      top = '0;
      pc = '0;
    endfunction

    function logic [STK_AW-1:0] disp_rd(int unsigned lv);
      return (lv < DISP_DEPTH) ? disp[lv] : '0;
    endfunction

    function void push(logic [31:0] v);
      stk[top] = v;
      top = top + 1'b1;
    endfunction

    function logic [31:0] pop();
      top = top - 1'b1;
      return stk[top];
    endfunction

    // Execute one instruction and note its expected result.
    function void note_instr(instr_t ins);
      res_t r;
      logic [31:0] a, b, v, q;
      logic [STK_AW-1:0] t1, saved;
      logic [CODE_AW-1:0] nxt;
      longint sum;
      r = '0;
      nxt = pc + 1'b1;
      case (ins.kind)
        K_LIT: push(ins.opd);
        K_LOD: push(stk[STK_AW'(32'(disp_rd(ins.lv)) + ins.opd)]);
        K_STO: begin
          v = pop();
          stk[STK_AW'(32'(disp_rd(ins.lv)) + ins.opd)] = v;
        end
        K_CAL: begin
          stk[top] = 32'(disp_rd(ins.lv + 1));
          stk[STK_AW'(top + 1)] = 32'(nxt);
          if (ins.lv + 1 < DISP_DEPTH) disp[ins.lv + 1] = top;
          nxt = ins.opd[CODE_AW-1:0];
        end
        K_RET: begin
          v = pop();
          top = disp_rd(ins.lv);
          if (ins.lv < DISP_DEPTH) disp[ins.lv] = stk[top][STK_AW-1:0];
          nxt = stk[STK_AW'(top + 1)][CODE_AW-1:0];
          top = top - ins.opd[STK_AW-1:0];
          push(v);
        end
        K_ICT: begin
          sum = longint'(top) + longint'($signed(ins.opd));
          if (sum < 0 || sum >= STK_LIMIT) r.fault = FLT_OVF;
          top = top + ins.opd[STK_AW-1:0];
        end
        K_JMP: nxt = ins.opd[CODE_AW-1:0];
        K_JPC: if (pop() == 0) nxt = ins.opd[CODE_AW-1:0];
        K_OPR: begin
          t1 = top - 1'b1;
          case (ins.op)
            OP_NEG: stk[t1] = -stk[t1];
            OP_ODD: stk[t1] = stk[t1] & 32'd1;
            OP_WRT: begin
              r.pval = pop();
              r.pkind = PK_NUM;
            end
            OP_NL: r.pkind = PK_NL;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_LT, OP_GT, OP_NE, OP_LE,
            OP_GE: begin
              b = pop();
              saved = top - 1'b1;
              a = stk[saved];
              v = a;
              case (ins.op)
                OP_ADD: v = a + b;
                OP_SUB: v = a - b;
                OP_MUL: v = a * b;
                OP_DIV: begin
                  if (b == 0) r.fault = FLT_DIV0;
                  else begin
                    // truncate toward zero on magnitudes; min / -1 wraps
                    q = (a[31] ? -a : a) / (b[31] ? -b : b);
                    v = (a[31] != b[31]) ? -q : q;
                  end
                end
                OP_EQ: v = 32'($signed(a) == $signed(b));
                OP_LT: v = 32'($signed(a) < $signed(b));
                OP_GT: v = 32'($signed(a) > $signed(b));
                OP_NE: v = 32'($signed(a) != $signed(b));
                OP_LE: v = 32'($signed(a) <= $signed(b));
                default: v = 32'($signed(a) >= $signed(b));
              endcase
              stk[saved] = v;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      pc = nxt;
      r.next_pc = nxt;
      r.halted = (nxt == 0);
      pending.push_back(r);
    endfunction

    function int check_result(res_t got);
      res_t e;
      int bad;
      bad = 0;
      if (pending.size() == 0) begin
        $error("result with nothing pending: %h", got);
        return 1;
      end
      e = pending.pop_front();
      if (got.next_pc !== e.next_pc) begin
        $error("next_pc expected %0d actual %0d", e.next_pc, got.next_pc);
        bad = 1;
      end
      if (got.halted !== e.halted) begin
        $error("halted expected %0d actual %0d", e.halted, got.halted);
        bad = 1;
      end
      if (got.pkind !== e.pkind) begin
        $error("print_kind expected %0d actual %0d", e.pkind, got.pkind);
        bad = 1;
      end
      if (got.pval !== e.pval) begin
        $error("print_value expected %h actual %h", e.pval, got.pval);
        bad = 1;
      end
      if (got.fault !== e.fault) begin
        $error("fault expected %0d actual %0d", e.fault, got.fault);
        bad = 1;
      end
      return bad;
    endfunction
  endclass

  pcode_scoreboard machine_model;

  pl0_stack_machine_step i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Often no gap at all, otherwise mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one instruction and hold it until the block takes it.
  task automatic send_instr(logic [3:0] kind, logic [3:0] op, logic [2:0] lv,
                            logic [31:0] opd);
    instr_t ins;
    int g;
    ins.kind = kind;
    ins.op = op;
    ins.lv = lv;
    ins.opd = opd;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'd0, ins.opd, ins.lv, ins.op, ins.kind};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    machine_model.note_instr(ins);
    n_sent++;
  endtask

  // Result side: check every accepted item, toggle ready with random stalls.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        n_fail += machine_model.check_result(res_t'(out_tdata[44:0]));
    end
  end

  initial begin
    int g;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      g = gap_len();
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Random operands biased toward edges so every bit and the sign flip.
  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 7);
      3: return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Well-formed sequence: call a routine that builds a frame, computes, sometimes prints, returns.
  task automatic run_frame();
    logic [2:0] lv;
    int i;
    lv = $urandom_range(0, 3);
    send_instr(K_CAL, OP_NEG, lv, $urandom_range(1, 255));
    send_instr(K_ICT, OP_NEG, 3'd0, $urandom_range(3, 6));
    for (i = 0; i < $urandom_range(1, 4); i++) begin
      send_instr(K_LIT, OP_NEG, 3'd0, rnd_word());
      send_instr(K_LIT, OP_NEG, 3'd0, ($urandom_range(0, 3) == 0) ? 32'd0 : rnd_word());
      send_instr(K_OPR, 4'($urandom_range(OP_ADD, OP_GE)), 3'd0, 32'd0);
      send_instr(K_STO, OP_NEG, lv + 3'd1, 32'd3);
      send_instr(K_LOD, OP_NEG, lv + 3'd1, 32'd3);
      send_instr(K_OPR, 4'($urandom_range(0, 1) ? OP_WRT : OP_ODD), 3'd0, 32'd0);
    end
    send_instr(K_RET, OP_NEG, lv + 3'd1, 32'($urandom_range(0, 2)));
  endtask

  task automatic run_noise();
    logic [3:0] k;
    logic [31:0] opd;
    k = $urandom_range(0, 15);
    opd = rnd_word();
    // keep ict steps small so the top stays in a sane region most of the time
    if (k == K_ICT && $urandom_range(0, 3) != 0) opd = $urandom_range(0, 8) - 4;
    send_instr(k, 4'($urandom()), 3'($urandom()), opd);
  endtask

  initial begin
    int n;
    machine_model = new();
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: edges, every op, divide by zero, min / -1, faults, unknown codes
    send_instr(K_LIT, OP_NEG, 3'd0, 32'h8000_0000);
    send_instr(K_LIT, OP_NEG, 3'd0, 32'hFFFF_FFFF);
    send_instr(K_OPR, OP_DIV, 3'd0, 32'd0);
    send_instr(K_LIT, OP_NEG, 3'd0, 32'd0);
    send_instr(K_OPR, OP_DIV, 3'd0, 32'd0);
    send_instr(K_OPR, OP_WRT, 3'd0, 32'd0);
    send_instr(K_OPR, OP_NL, 3'd0, 32'd0);
    send_instr(K_ICT, OP_NEG, 3'd0, 32'd2100);
    send_instr(K_ICT, OP_NEG, 3'd0, 32'hFFFF_F7CC);
    send_instr(K_ICT, OP_NEG, 3'd0, 32'hFFFF_FFFF);
    send_instr(K_ICT, OP_NEG, 3'd0, 32'd10);
    send_instr(K_CAL, OP_NEG, 3'd7, 32'hFFFF_FF05);
    send_instr(K_CAL, OP_NEG, 3'd4, 32'd9);
    send_instr(K_RET, OP_NEG, 3'd5, 32'hFFFF_FFFF);
    send_instr(K_LOD, OP_NEG, 3'd7, 32'h7FFF_FFFF);
    send_instr(K_STO, OP_NEG, 3'd0, 32'h8000_0000);
    send_instr(K_JPC, OP_NEG, 3'd0, 32'd0);
    send_instr(K_JMP, OP_NEG, 3'd0, 32'h0000_0100);
    send_instr(K_NOP, OP_NEG, 3'd0, 32'd0);
    send_instr(K_OPR, 4'd15, 3'd0, 32'd0);
    send_instr(4'd9, 4'd14, 3'd0, 32'd0);
    for (n = 0; n <= 11; n++) send_instr(K_OPR, 4'(n), 3'd0, 32'd0);

    while (n_sent < 950) begin
      if ($urandom_range(0, 3) != 0) begin
        run_frame();
      end else begin
        run_noise();
      end
    end
    in_tvalid <= 1'b0;

    n = 0;
    while (machine_model.pending.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (100) @(posedge clk);
    if (n_fail == 0 && machine_model.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("simulation failed");
    $finish;
  end

endmodule
